/* hdl/ogi_pkg.sv */
// shared constants, register codes and types of the obstacle inflation block
`default_nettype none
package ogi_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 15;
    localparam int MAX_HEIGHT     = 4096;

    localparam int PIX_W  = 8;
    localparam int THR_W  = 8;
    localparam int RAD_W  = 4;
    localparam int IW_W   = 11;
    localparam int IH_W   = 13;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam int OUT_DEPTH = 3;
    localparam int OUT_CNT_W = 2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_RADIUS    = 2'd1;
    localparam logic [1:0] REG_WIDTH     = 2'd2;
    localparam logic [1:0] REG_HEIGHT    = 2'd3;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd125;
    localparam logic [RAD_W-1:0] RADIUS_RST    = 4'd13;
    localparam logic [IW_W-1:0]  WIDTH_RST     = 11'd1024;
    localparam logic [IH_W-1:0]  HEIGHT_RST    = 13'd1024;

    typedef struct packed {
        logic [THR_W-1:0] thr;
        logic [RAD_W-1:0] radius;
        logic [IW_W-1:0]  width;
        logic [IH_W-1:0]  height;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             frame_end;
    } res_t;

endpackage
`default_nettype wire

/* hdl/ogi_apb_regs.sv */
// apb configuration registers of the obstacle inflation block
`default_nettype none
module ogi_apb_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ogi_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ogi_pkg::APB_DW-1:0]   pwdata,
    output logic      [ogi_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output ogi_pkg::cfg_t                     cfg,
    output logic                              radius_wr
);

    ogi_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    idx;

    assign pready    = 1'b1;
    assign idx       = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign radius_wr = wr_en && (idx == ogi_pkg::REG_RADIUS);
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thr    <= ogi_pkg::THRESHOLD_RST;
            cfg_reg.radius <= ogi_pkg::RADIUS_RST;
            cfg_reg.width  <= ogi_pkg::WIDTH_RST;
            cfg_reg.height <= ogi_pkg::HEIGHT_RST;
        end else if (wr_en) begin
            unique case (idx)
                ogi_pkg::REG_THRESHOLD: cfg_reg.thr    <= pwdata[ogi_pkg::THR_W-1:0];
                ogi_pkg::REG_RADIUS:    cfg_reg.radius <= pwdata[ogi_pkg::RAD_W-1:0];
                ogi_pkg::REG_WIDTH:     cfg_reg.width  <= pwdata[ogi_pkg::IW_W-1:0];
                ogi_pkg::REG_HEIGHT:    cfg_reg.height <= pwdata[ogi_pkg::IH_W-1:0];
                default:                cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ogi_pkg::REG_THRESHOLD: prdata = ogi_pkg::APB_DW'(cfg_reg.thr);
            ogi_pkg::REG_RADIUS:    prdata = ogi_pkg::APB_DW'(cfg_reg.radius);
            ogi_pkg::REG_WIDTH:     prdata = ogi_pkg::APB_DW'(cfg_reg.width);
            ogi_pkg::REG_HEIGHT:    prdata = ogi_pkg::APB_DW'(cfg_reg.height);
            default:                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/ogi_mod_unit.sv */
// bit-serial remainder unit: column and row phase modulo the radius
`default_nettype none
module ogi_mod_unit #(
    parameter int MAX_WIDTH  = ogi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = ogi_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        start,
    input  wire logic [$clog2(MAX_RADIUS+1)-1:0]             divisor,
    input  wire logic [$clog2(MAX_WIDTH+MAX_RADIUS)-1:0]     col,
    input  wire logic [$clog2(ogi_pkg::MAX_HEIGHT+MAX_RADIUS)-1:0] row,
    output logic                                             busy,
    output logic                                             done,
    output logic [((MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1)-1:0] col_rem,
    output logic [((MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1)-1:0] row_rem
);

    localparam int XW    = $clog2(MAX_WIDTH + MAX_RADIUS);
    localparam int YW    = $clog2(ogi_pkg::MAX_HEIGHT + MAX_RADIUS);
    localparam int NB    = (XW > YW) ? XW : YW;
    localparam int CNT_W = $clog2(NB);
    localparam int RADW  = $clog2(MAX_RADIUS + 1);
    localparam int RW    = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
    localparam int RMW   = $clog2(2 * MAX_RADIUS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NB-1:0]    xsh_reg;
    logic [NB-1:0]    ysh_reg;
    logic [RMW-1:0]   remx_reg;
    logic [RMW-1:0]   remy_reg;
    logic [RADW-1:0]  div_reg;
    logic [RMW-1:0]   remx_next;
    logic [RMW-1:0]   remy_next;
    logic [RMW-1:0]   tx;
    logic [RMW-1:0]   ty;
    logic [RMW-1:0]   dv;

    // restoring step, one bit of each value per cycle
    always_comb begin
        dv        = RMW'(div_reg);
        tx        = RMW'({remx_reg, xsh_reg[NB-1]});
        ty        = RMW'({remy_reg, ysh_reg[NB-1]});
        remx_next = (tx >= dv) ? tx - dv : tx;
        remy_next = (ty >= dv) ? ty - dv : ty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NB - 1);
                xsh_reg  <= NB'(col);
                ysh_reg  <= NB'(row);
                remx_reg <= '0;
                remy_reg <= '0;
                div_reg  <= divisor;
            end else if (busy_reg) begin
                remx_reg <= remx_next;
                remy_reg <= remy_next;
                xsh_reg  <= xsh_reg << 1;
                ysh_reg  <= ysh_reg << 1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign col_rem = RW'(remx_reg);
    assign row_rem = RW'(remy_reg);

endmodule
`default_nettype wire

/* hdl/ogi_out_fifo.sv */
// three-entry result queue between the pipeline and the output port
`default_nettype none
module ogi_out_fifo (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            push,
    input  wire ogi_pkg::res_t                   push_data,
    input  wire logic                            pop,
    output ogi_pkg::res_t                        head,
    output logic                                 not_empty,
    output logic [ogi_pkg::OUT_CNT_W-1:0]        count
);

    localparam int DEPTH = ogi_pkg::OUT_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    ogi_pkg::res_t                  mem_reg [DEPTH];
    logic [PW-1:0]                  wr_ptr_reg;
    logic [PW-1:0]                  rd_ptr_reg;
    logic [ogi_pkg::OUT_CNT_W-1:0]  count_reg;
    logic [PW-1:0]                  wr_ptr_next;
    logic [PW-1:0]                  rd_ptr_next;

    assign wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
    assign rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            priority if (push && !pop) begin
                count_reg <= count_reg + ogi_pkg::OUT_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - ogi_pkg::OUT_CNT_W'(1);
            end else begin
                count_reg <= count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule
`default_nettype wire

/* hdl/occupancy_grid_obstacle_inflation.sv */
// occupancy map obstacle inflation: square-window dilation over a padded raster
// a result is offered, via stage 1 and the queue, after padded request (r+R, c+R)
// throughput: one pixel per cycle when not stalled, set by the read-first row-delay
//   pixel ram and column gap ram read-modify-write (write next cycle, forwarded)
// a write to inflate_radius stalls input while the bit-serial remainder unit
//   recomputes the row and column phases
// reset clears raster position, row window and control; rams are not cleared
`default_nettype none
module occupancy_grid_obstacle_inflation #(
    parameter int MAX_WIDTH  = ogi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = ogi_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ogi_pkg::APB_AW-1:0]    paddr,
    input  wire logic [ogi_pkg::APB_DW-1:0]    pwdata,
    output logic      [ogi_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ogi_pkg::PIX_W-1:0]     s_pixel_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [ogi_pkg::PIX_W-1:0]     m_out_value,
    output logic                               m_frame_end
);

    localparam int GAP_SAT = 2 * MAX_RADIUS + 1;
    localparam int GW      = $clog2(GAP_SAT + 1);
    localparam int SHW     = $clog2(GAP_SAT + 1);
    localparam int XW      = $clog2(MAX_WIDTH + MAX_RADIUS);
    localparam int YW      = $clog2(ogi_pkg::MAX_HEIGHT + MAX_RADIUS);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(ogi_pkg::MAX_HEIGHT + 1);
    localparam int RADW    = $clog2(MAX_RADIUS + 1);
    localparam int RW      = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int PAW     = $clog2(MAX_RADIUS * MAX_WIDTH);
    localparam int PXW     = ogi_pkg::PIX_W;

    ogi_pkg::cfg_t cfg;
    logic          radius_wr;

    ogi_apb_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .radius_wr (radius_wr)
    );

    // raster state
    logic [XW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    logic [RW-1:0]      cs_reg;
    logic [RW-1:0]      ys_reg;
    logic [GAP_SAT-1:0] win_reg;
    logic               start_reg;

    // effective configuration
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [RADW-1:0] r_eff;

    always_comb begin
        priority if (cfg.width == '0) begin
            w_eff = WW'(1);
        end else if (int'(cfg.width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg.width);
        end
        priority if (cfg.height == '0) begin
            h_eff = HW'(1);
        end else if (int'(cfg.height) > ogi_pkg::MAX_HEIGHT) begin
            h_eff = HW'(ogi_pkg::MAX_HEIGHT);
        end else begin
            h_eff = HW'(cfg.height);
        end
        if (int'(cfg.radius) > MAX_RADIUS) begin
            r_eff = RADW'(MAX_RADIUS);
        end else begin
            r_eff = RADW'(cfg.radius);
        end
    end

    // phase recompute after a radius change
    logic          mod_busy;
    logic          mod_done;
    logic [RW-1:0] mod_cs;
    logic [RW-1:0] mod_ys;

    ogi_mod_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .divisor (r_eff),
        .col     (x_reg),
        .row     (y_reg),
        .busy    (mod_busy),
        .done    (mod_done),
        .col_rem (mod_cs),
        .row_rem (mod_ys)
    );

    // stage 0: request cycle
    logic [XW-1:0]      wx;
    logic [XW-1:0]      rx;
    logic [YW-1:0]      hy;
    logic [YW-1:0]      ry;
    logic               x_in;
    logic               y_in;
    logic               x_last;
    logic               y_last;
    logic               ob;
    logic [GAP_SAT-1:0] win_base;
    logic [GAP_SAT-1:0] win_next;
    logic [GAP_SAT-1:0] win_mask;
    logic [GAP_SAT-1:0] ones;
    logic [SHW-1:0]     r2p1;
    logic               hflag;
    logic [XW-1:0]      c_full;
    logic [CW-1:0]      c_idx;
    logic [YW-1:0]      orow;
    logic               col_ok;
    logic               row_ok;
    logic               emit;
    logic               fe;
    logic               r_nz;
    logic               pram_en;
    logic [PAW-1:0]     pram_addr;
    logic [RADW-1:0]    cs_p1;
    logic [RADW-1:0]    ys_p1;
    logic [RW-1:0]      cs_next;
    logic [RW-1:0]      ys_next;
    logic               acc;
    logic               busy;

    always_comb begin
        wx       = XW'(w_eff);
        rx       = XW'(r_eff);
        hy       = YW'(h_eff);
        ry       = YW'(r_eff);
        x_in     = x_reg < wx;
        y_in     = y_reg < hy;
        x_last   = x_reg >= wx + rx - XW'(1);
        y_last   = y_reg >= hy + ry - YW'(1);
        ob       = x_in && y_in && (s_pixel_value < cfg.thr);
        win_base = (x_reg == '0) ? '0 : win_reg;
        win_next = {win_base[GAP_SAT-2:0], ob};
        ones     = '1;
        r2p1     = SHW'({r_eff, 1'b1});
        win_mask = ~(ones << r2p1);
        hflag    = |(win_next & win_mask);
        c_full   = x_reg - rx;
        c_idx    = CW'(c_full);
        orow     = y_reg - ry;
        col_ok   = (x_reg >= rx) && (c_full < wx);
        row_ok   = (y_reg >= ry) && (orow < hy);
        emit     = col_ok && row_ok;
        fe       = (orow == hy - YW'(1)) && (c_full == wx - XW'(1));
        r_nz     = (r_eff != '0);
        pram_en  = r_nz && x_in;
        pram_addr = PAW'(PAW'(ys_reg) * PAW'(MAX_WIDTH)) + PAW'(x_reg);
        cs_p1    = RADW'(cs_reg) + RADW'(1);
        ys_p1    = RADW'(ys_reg) + RADW'(1);
        cs_next  = (cs_p1 >= r_eff) ? '0 : RW'(cs_p1);
        ys_next  = (ys_p1 >= r_eff) ? '0 : RW'(ys_p1);
    end

    // stage 1 registers
    logic            s1_valid_reg;
    logic            s1_emit_reg;
    logic            s1_fe_reg;
    logic            s1_gap_wr_reg;
    logic [CW-1:0]   s1_c_reg;
    logic            s1_hflag_reg;
    logic            s1_y0_reg;
    logic [GW-1:0]   s1_r2_reg;
    logic [PXW-1:0]  s1_pix_reg;
    logic            s1_store_rd_reg;
    logic            s1_use_dsp_reg;
    logic            s1_dsp_wr_reg;
    logic [RW-1:0]   s1_cs_reg;
    logic            s1_fwd_reg;
    logic [GW-1:0]   fwd_data_reg;
    logic [PXW-1:0]  prd_reg;
    logic [GW-1:0]   grd_reg;

    // memories
    logic [PXW-1:0]  pixel_ram [MAX_RADIUS * MAX_WIDTH];
    logic [GW-1:0]   gap_ram   [MAX_WIDTH];
    logic [PXW-1:0]  dsp_reg   [MAX_RADIUS];

    // stage 1 logic
    logic [GW-1:0]   gap_old;
    logic [GW-1:0]   g1;
    logic [PXW-1:0]  row_del;
    logic [PXW-1:0]  col_del;
    logic            blocked;
    logic            fwd_next;
    ogi_pkg::res_t   s1_res;

    always_comb begin
        gap_old = s1_fwd_reg ? fwd_data_reg : grd_reg;
        priority if (s1_hflag_reg) begin
            g1 = '0;
        end else if (s1_y0_reg) begin
            g1 = GW'(GAP_SAT);
        end else if (gap_old >= GW'(GAP_SAT)) begin
            g1 = GW'(GAP_SAT);
        end else begin
            g1 = gap_old + GW'(1);
        end
        row_del = s1_store_rd_reg ? prd_reg : s1_pix_reg;
        col_del = s1_use_dsp_reg ? dsp_reg[s1_cs_reg] : s1_pix_reg;
        blocked = (g1 <= s1_r2_reg);
        s1_res.value     = blocked ? '0 : col_del;
        s1_res.frame_end = s1_fe_reg;
        // same column read while the previous request still writes it
        fwd_next = s1_valid_reg && s1_gap_wr_reg && col_ok && (s1_c_reg == c_idx);
    end

    // output queue and flow control
    ogi_pkg::res_t                 head;
    logic                          q_not_empty;
    logic [ogi_pkg::OUT_CNT_W-1:0] q_count;
    logic                          q_push;
    logic [ogi_pkg::OUT_CNT_W:0]   q_need;

    assign q_push  = s1_valid_reg && s1_emit_reg;
    assign q_need  = (ogi_pkg::OUT_CNT_W + 1)'(q_count)
                     + (ogi_pkg::OUT_CNT_W + 1)'(q_push);
    assign busy    = start_reg || mod_busy || mod_done;
    assign s_ready = !busy && (q_need < (ogi_pkg::OUT_CNT_W + 1)'(ogi_pkg::OUT_DEPTH));
    assign acc     = s_valid && s_ready;

    ogi_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (s1_res),
        .pop       (m_valid && m_ready),
        .head      (head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign m_valid     = q_not_empty;
    assign m_out_value = head.value;
    assign m_frame_end = head.frame_end;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg        <= '0;
            y_reg        <= '0;
            cs_reg       <= '0;
            ys_reg       <= '0;
            win_reg      <= '0;
            start_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end else begin
            start_reg    <= radius_wr;
            s1_valid_reg <= acc;
            s1_fwd_reg   <= acc && fwd_next;
            if (mod_done) begin
                cs_reg <= mod_cs;
                ys_reg <= mod_ys;
            end else if (acc) begin
                win_reg <= win_next;
                if (x_last) begin
                    x_reg  <= '0;
                    cs_reg <= '0;
                    if (y_last) begin
                        y_reg  <= '0;
                        ys_reg <= '0;
                    end else begin
                        y_reg  <= y_reg + YW'(1);
                        ys_reg <= ys_next;
                    end
                end else begin
                    x_reg  <= x_reg + XW'(1);
                    cs_reg <= cs_next;
                end
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_emit_reg     <= emit;
            s1_fe_reg       <= fe;
            s1_gap_wr_reg   <= col_ok;
            s1_c_reg        <= c_idx;
            s1_hflag_reg    <= hflag;
            s1_y0_reg       <= (y_reg == '0);
            s1_r2_reg       <= GW'({r_eff, 1'b0});
            s1_pix_reg      <= s_pixel_value;
            s1_store_rd_reg <= pram_en;
            s1_use_dsp_reg  <= r_nz;
            s1_dsp_wr_reg   <= pram_en;
            s1_cs_reg       <= cs_reg;
            fwd_data_reg    <= g1;
        end
    end

    // row delay: read-first, the same entry comes back R rows later
    always_ff @(posedge aclk) begin
        if (acc && pram_en) begin
            prd_reg              <= pixel_ram[pram_addr];
            pixel_ram[pram_addr] <= s_pixel_value;
        end
    end

    // per-column rows since the last flagged row
    always_ff @(posedge aclk) begin
        if (acc && col_ok) begin
            grd_reg <= gap_ram[c_idx];
        end
        if (s1_valid_reg && s1_gap_wr_reg) begin
            gap_ram[s1_c_reg] <= g1;
        end
    end

    // column delay, one slot per phase
    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_dsp_wr_reg) begin
            dsp_reg[s1_cs_reg] <= row_del;
        end
    end

endmodule
`default_nettype wire

/* hdl/ogi_checker.sv */
// port-level checks of the obstacle inflation block and their bind
`default_nettype none
module ogi_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [ogi_pkg::APB_AW-1:0]    paddr,
    input wire logic                          pready,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [ogi_pkg::PIX_W-1:0]     m_out_value,
    input wire logic                          m_frame_end
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value) && $stable(m_frame_end))
        else $error("stalled result changed");

    // reset empties the result queue
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // a newly offered result must follow an accepted request, through stage 1 and the output queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching request");

    // a radius write stalls input while phases are recomputed
    assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && (paddr[3:2] == ogi_pkg::REG_RADIUS)
        |=> !s_ready)
        else $error("input taken during phase recompute");

endmodule

bind occupancy_grid_obstacle_inflation ogi_checker u_checker (.*);
`default_nettype wire
